// ===== hw/rtl/b64e_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 stream encoder
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  localparam int unsigned SymW     = 6;
  localparam int unsigned CharW    = 8;
  localparam int unsigned Slots    = 4;
  localparam int unsigned SlotW    = 2;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = 1;
  localparam int unsigned QCntW    = 2;
  localparam logic [CharW-1:0] PadChar = 8'h3d;

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_e;

  // characters of one input byte, slot 0 first
  typedef struct packed {
    logic [Slots-1:0][SymW-1:0] sym;
    logic [Slots-1:0]           pad;
    logic [SlotW-1:0]           last_idx;
    logic                       last;
  } job_t;

  function automatic logic [CharW-1:0] b64_char(input logic [SymW-1:0] v);
    logic [CharW-1:0] c;
    c = {2'b00, v};
    if (v < 6'd26) begin
      b64_char = 8'h41 + c;
    end else if (v < 6'd52) begin
      b64_char = 8'h61 + c - 8'd26;
    end else if (v < 6'd62) begin
      b64_char = 8'h30 + c - 8'd52;
    end else if (v == 6'd62) begin
      b64_char = 8'h2b;
    end else begin
      b64_char = 8'h2f;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64e_front.sv =====
// front end: tracks group phase and carry bits and splits each byte into symbols
`timescale 1ns / 1ps
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [CharW-1:0] in_byte_i,
  input  wire logic             in_last_i,
  output logic                  in_ready_o,
  output logic                  job_valid_o,
  output job_t                  job_o,
  input  wire logic             job_ready_i
);

  phase_e     phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic       accept;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign accept      = in_valid_i && job_ready_i;

  always_comb begin
    job_o          = '0;
    job_o.last     = in_last_i;
    phase_d        = phase_q;
    carry_d        = carry_q;
    case (phase_q)
      PH_1: begin
        job_o.sym[0] = {carry_q[1:0], in_byte_i[7:4]};
        carry_d      = in_byte_i[3:0];
        phase_d      = PH_2;
        if (in_last_i) begin
          job_o.sym[1]   = {in_byte_i[3:0], 2'b00};
          job_o.pad[2]   = 1'b1;
          job_o.last_idx = 2'd2;
        end
      end
      PH_2: begin
        job_o.sym[0]   = {carry_q, in_byte_i[7:6]};
        job_o.sym[1]   = in_byte_i[5:0];
        job_o.last_idx = 2'd1;
        carry_d        = 4'd0;
        phase_d        = PH_0;
      end
      default: begin
        job_o.sym[0] = in_byte_i[7:2];
        carry_d      = {2'b00, in_byte_i[1:0]};
        phase_d      = PH_1;
        if (in_last_i) begin
          job_o.sym[1]   = {in_byte_i[1:0], 4'b0000};
          job_o.pad[2]   = 1'b1;
          job_o.pad[3]   = 1'b1;
          job_o.last_idx = 2'd3;
        end
      end
    endcase
    if (in_last_i) begin
      phase_d = PH_0;
      carry_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_0;
      carry_q <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/b64e_queue.sv =====
// two-entry job queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue
  import b64e_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  input  wire job_t push_job_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output job_t      pop_job_o,
  input  wire logic pop_ready_i
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/b64e_back.sv =====
// back end: walks each job's slots, one character per cycle while a job waits and output is ready
`timescale 1ns / 1ps
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             job_valid_i,
  input  wire job_t             job_i,
  output logic                  job_ready_o,
  output logic                  out_valid_o,
  output logic [CharW-1:0]      out_char_o,
  output logic                  out_last_o,
  input  wire logic             out_ready_i
);

  logic [SlotW-1:0] idx_q;
  logic             valid_q;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q;
  logic             load, final_slot;

  assign load        = job_valid_i && (!valid_q || out_ready_i);
  assign final_slot  = (idx_q == job_i.last_idx);
  assign job_ready_o = load && final_slot;
  assign char_d      = job_i.pad[idx_q] ? PadChar : b64_char(job_i.sym[idx_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= final_slot ? '0 : idx_q + 1'b1;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      last_q <= final_slot && job_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/base64_stream_encoder.sv =====
// base64 stream encoder top level
// a byte is written into the job queue, and its first character is then registered in the back end's output register
// throughput: one character per cycle while a job is queued and the output is ready; a byte gives one to four
//   characters, so a long message sustains three bytes per four characters, set by the single output port
// a two-entry job queue lets input words keep arriving while characters drain
// reset: group phase and carry bits clear, queue and output register empty
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder
  import b64e_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_char
  output logic            m_axis_tlast_o
);

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_byte_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .job_valid_o (f_valid),
    .job_o       (f_job),
    .job_ready_i (f_ready)
  );

  b64e_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_job_i   (f_job),
    .push_ready_o (f_ready),
    .pop_valid_o  (b_valid),
    .pop_job_o    (b_job),
    .pop_ready_i  (b_ready)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_valid),
    .job_i       (b_job),
    .job_ready_o (b_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_ready_i (m_axis_tready_i)
  );

endmodule

`default_nettype wire

// ===== tb/tb_base64_stream_encoder.sv =====
// testbench for the base64 stream encoder: directed and random messages checked against a local encoder
`timescale 1ns / 1ps

module tb_base64_stream_encoder;
  import b64e_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } b64_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;  // [7:0] in_byte
  logic       s_axis_tlast_i = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;          // [7:0] out_char
  logic       m_axis_tlast_o;

  string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  phase_e     enc_phase = PH_0;
  logic [3:0] enc_carry = 4'h0;
  b64_word_t  pending_chars[$];
  int         err_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  base64_stream_encoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic push_char(input logic [7:0] ch);
    b64_word_t w;
    w.ch   = ch;
    w.last = 1'b0;
    pending_chars.push_back(w);
  endtask

  task automatic push_sextet(input logic [5:0] v);
    push_char(alphabet[v]);
  endtask

  // expected characters for one accepted byte
  task automatic encode_byte(input logic [7:0] b, input logic last);
    case (enc_phase)
      PH_1: begin
        push_sextet({enc_carry[1:0], b[7:4]});
        enc_carry = b[3:0];
        enc_phase = PH_2;
        if (last) begin
          push_sextet({enc_carry, 2'b00});
          push_char(PadChar);
        end
      end
      PH_2: begin
        push_sextet({enc_carry, b[7:6]});
        push_sextet(b[5:0]);
        enc_carry = 4'h0;
        enc_phase = PH_0;
      end
      default: begin
        push_sextet(b[7:2]);
        enc_carry = {2'b00, b[1:0]};
        enc_phase = PH_1;
        if (last) begin
          push_sextet({enc_carry[1:0], 4'h0});
          push_char(PadChar);
          push_char(PadChar);
        end
      end
    endcase
    if (last) begin
      pending_chars[pending_chars.size()-1].last = 1'b1;
      enc_phase = PH_0;
      enc_carry = 4'h0;
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    encode_byte(b, last);
  endtask

  // output side: check each accepted word, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected word: out_char %h out_last %b", m_axis_tdata_o, m_axis_tlast_o);
        err_count++;
      end else begin
        if (m_axis_tdata_o !== pending_chars[0].ch) begin
          $error("out_char: expected %h actual %h", pending_chars[0].ch, m_axis_tdata_o);
          err_count++;
        end
        if (m_axis_tlast_o !== pending_chars[0].last) begin
          $error("out_last: expected %b actual %b", pending_chars[0].last, m_axis_tlast_o);
          err_count++;
        end
        void'(pending_chars.pop_front());
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one-byte messages: two pad characters
  task automatic test_two_pad;
    send_word(8'h00, 1'b1);
    send_word(8'hff, 1'b1);
  endtask

  // two-byte messages: one pad character
  task automatic test_one_pad;
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b1);
  endtask

  // full groups: no padding
  task automatic test_full_group;
    send_word(8'hfb, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'hbf, 1'b1);
    send_word(8'h66, 1'b0);
    send_word(8'h6f, 1'b0);
    send_word(8'h6f, 1'b1);
  endtask

  // message across several groups ending in a partial group
  task automatic test_multi_group;
    send_word(8'h4d, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h6e, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h01, 1'b1);
  endtask

  task automatic test_random_messages(input int n_words, input int idle_pct, input int stall_pct);
    int         sent;
    int         len;
    logic [7:0] b;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_words) begin
      len = $urandom_range(9, 1);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(7))
          0:       b = 8'h00;
          1:       b = 8'hff;
          default: b = 8'($urandom_range(255));
        endcase
        send_word(b, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_two_pad();
    test_one_pad();
    test_full_group();
    test_multi_group();
    test_random_messages(37, 27, 73);
    test_random_messages(37, 73, 27);
    test_random_messages(37, 0, 0);
    s_axis_tvalid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
